// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the relative contrast query RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RCQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RCQ_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define RCQ_ASSERT(lbl, clk, rstn, prop)
`define RCQ_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- hdl/rcq_pkg.sv -----
// Types and constants of the relative contrast query block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package rcq_pkg;
  localparam int ELEM_W     = 16;
  localparam int DIST_W     = 44;
  localparam int SUM_W      = 60;
  localparam int CNT_W      = 17;
  localparam int CONTRAST_W = 32;
  localparam int FRAC_W     = 32;
  localparam int QUOT_W     = 64;
  localparam int ITER_W     = 7;

  localparam logic [DIST_W-1:0] CEILING_RESET = 44'd6553600000;
  localparam logic [DIST_W-1:0] DIST_MAX      = {DIST_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CONTRAST_W-1:0] CONTRAST_SAT = {CONTRAST_W{1'b1}};

  localparam logic [ITER_W-1:0] MEAN_LAST  = ITER_W'(SUM_W - 1);
  localparam logic [ITER_W-1:0] RATIO_LAST = ITER_W'(DIST_W + FRAC_W - 1);
  localparam logic [ITER_W-1:0] ROOT_LAST  = ITER_W'(QUOT_W / 2 - 1);

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] min;
  } job_t;
endpackage

// ----- hdl/relative_contrast_query_core.sv -----
// Relative contrast query: element pairs in, one result per query out.
// Input: one element pair per cycle while the result queue has room; the front hands
// query totals to the queue through its s1 and s2 registers. Back end: load, 60
// mean-division steps, a check, 76 ratio-division steps and 32 root steps, then the
// output register (the ratio and root steps are skipped when the contrast saturates).
// Reset (rst_ni, async, low) clears all control state and loads the ceiling with 100000.0.
`timescale 1ns / 1ps
module relative_contrast_query_core import rcq_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // data_elem, query_elem
  input  logic          s_axis_tlast,   // last_elem
  input  logic          s_axis_tuser,   // last_point
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,   // contrast, mean_dist, min_dist
  output logic          m_axis_tuser,   // zero_min
  input  logic          cfg_we_i,
  input  logic [DIST_W-1:0] cfg_wdata_i
);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic                  push, pop, q_valid;
  job_t                  push_job, pop_job;
  logic [CW-1:0]         q_count;
  logic [CONTRAST_W-1:0] contrast;
  logic [DIST_W-1:0]     mean_dist, min_dist;

  rcq_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_elem_i  (s_axis_tdata[15:0]),
    .query_elem_i (s_axis_tdata[31:16]),
    .last_elem_i  (s_axis_tlast),
    .last_point_i (s_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  rcq_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .pop_i       (pop),
    .pop_job_o   (pop_job),
    .not_empty_o (q_valid),
    .count_o     (q_count)
  );

  rcq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .contrast_o  (contrast),
    .mean_dist_o (mean_dist),
    .min_dist_o  (min_dist),
    .zero_min_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {min_dist, mean_dist, contrast};
endmodule

// ----- hdl/rcq_front.sv -----
// Front end: squares element differences, accumulates point distances,
// and keeps the query sum, minimum and count. Depends on rcq_pkg.
`timescale 1ns / 1ps
module rcq_front import rcq_pkg::*; #(
  parameter int FIFO_DEPTH = 4,
  localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ELEM_W-1:0] data_elem_i,
  input  logic signed [ELEM_W-1:0] query_elem_i,
  input  logic                     last_elem_i,
  input  logic                     last_point_i,
  input  logic                     cfg_we_i,
  input  logic [DIST_W-1:0]        cfg_wdata_i,
  input  logic [CW-1:0]            q_count_i,
  output logic                     push_o,
  output job_t                     push_job_o
);
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W-1:0]      mag;
  logic                   accept;
  logic [CW:0]            pending;

  logic                   s1_valid_q;
  logic [2*ELEM_W-1:0]    s1_sq_q;
  logic                   s1_le_q, s1_lp_q;
  logic [DIST_W-1:0]      pd_q;
  logic [DIST_W:0]        pd_sum;
  logic [DIST_W-1:0]      pd_sat;

  logic                   s2_valid_q, s2_lp_q;
  logic [DIST_W-1:0]      s2_dist_q;

  logic [DIST_W-1:0]      ceiling_q, min_q, min_n;
  logic [SUM_W-1:0]       sum_q, sum_n;
  logic [SUM_W:0]         sum_add;
  logic [CNT_W-1:0]       cnt_q, cnt_n;
  logic                   nonzero;

  assign diff   = (ELEM_W+1)'(data_elem_i) - (ELEM_W+1)'(query_elem_i);
  assign mag    = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
  assign accept = in_valid_i && in_ready_o;

  assign pending = {1'b0, q_count_i} + (CW+1)'(s1_valid_q && s1_lp_q)
                 + (CW+1)'(s2_valid_q && s2_lp_q);
  assign in_ready_o = pending < (CW+1)'(FIFO_DEPTH);

  assign pd_sum = {1'b0, pd_q} + (DIST_W+1)'(s1_sq_q);
  assign pd_sat = pd_sum[DIST_W] ? DIST_MAX : pd_sum[DIST_W-1:0];

  assign nonzero = s2_dist_q != '0;
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(s2_dist_q);
  assign sum_n   = !nonzero ? sum_q : (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);
  assign min_n   = (nonzero && s2_dist_q < min_q) ? s2_dist_q : min_q;
  assign cnt_n   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);

  assign push_o           = s2_valid_q && s2_lp_q;
  assign push_job_o.sum   = sum_n;
  assign push_job_o.count = cnt_n;
  assign push_job_o.min   = min_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_le_q    <= 1'b0;
      s1_lp_q    <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_lp_q    <= 1'b0;
      pd_q       <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      min_q      <= CEILING_RESET;
      ceiling_q  <= CEILING_RESET;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        s1_le_q <= last_elem_i;
        s1_lp_q <= last_elem_i && last_point_i;
      end
      s2_valid_q <= s1_valid_q && s1_le_q;
      if (s1_valid_q) begin
        pd_q <= s1_le_q ? '0 : pd_sat;
        if (s1_le_q) begin
          s2_lp_q <= s1_lp_q;
        end
      end
      if (s2_valid_q) begin
        if (s2_lp_q) begin
          sum_q <= '0;
          cnt_q <= '0;
          min_q <= ceiling_q;
        end else begin
          sum_q <= sum_n;
          cnt_q <= cnt_n;
          min_q <= min_n;
        end
      end
      if (cfg_we_i) begin
        ceiling_q <= cfg_wdata_i;
        if (cnt_q == '0 && !s2_valid_q) begin
          min_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sq_q <= (2*ELEM_W)'(mag) * (2*ELEM_W)'(mag);
    end
    if (s1_valid_q && s1_le_q) begin
      s2_dist_q <= pd_sat;
    end
  end
endmodule

// ----- hdl/rcq_fifo.sv -----
// Short queue of finished query totals between the front and back ends.
// Depends on rcq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rcq_fifo import rcq_pkg::*; #(
  parameter int FIFO_DEPTH = 4,
  localparam int CW = $clog2(FIFO_DEPTH + 1),
  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          push_job_i,
  input  logic          pop_i,
  output job_t          pop_job_o,
  output logic          not_empty_o,
  output logic [CW-1:0] count_o
);
  job_t          mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign not_empty_o = count_q != '0;
  assign count_o     = count_q;
  assign pop_job_o   = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_job_i;
    end
  end

  `RCQ_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !pop_i && count_q == CW'(FIFO_DEPTH))
  `RCQ_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && count_q == '0)
  `RCQ_ASSERT(a_count_track, clk_i, rst_ni, (push_i && !pop_i) |=> count_q == $past(count_q) + CW'(1))
endmodule

// ----- hdl/rcq_back.sv -----
// Back end: iterative mean division, ratio division and square root,
// with an output register. Depends on rcq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rcq_back import rcq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  job_t                  job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CONTRAST_W-1:0] contrast_o,
  output logic [DIST_W-1:0]     mean_dist_o,
  output logic [DIST_W-1:0]     min_dist_o,
  output logic                  zero_min_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_MEAN, ST_CHECK, ST_RATIO, ST_ROOT, ST_DONE
  } state_e;

  state_e                     state_q;
  logic [ITER_W-1:0]          iter_q;
  logic [SUM_W-1:0]           sh_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [DIST_W-1:0]          min_q, mean_q, rem_q;
  logic [DIST_W+FRAC_W-1:0]   div_q;
  logic [QUOT_W-1:0]          quot_q;
  logic [CONTRAST_W+1:0]      srem_q;
  logic [CONTRAST_W-1:0]      root_q;
  logic                       zero_q;

  logic [CNT_W:0]             m_try;
  logic                       m_ge;
  logic [DIST_W-1:0]          mean_sat;
  logic [DIST_W:0]            r_try;
  logic                       r_ge;
  logic [CONTRAST_W+2:0]      s_try, s_trial;
  logic                       s_ge;
  logic                       out_free;

  assign m_try    = {rem_q[CNT_W-1:0], sh_q[SUM_W-1]};
  assign m_ge     = m_try >= {1'b0, cnt_q};
  assign mean_sat = (sh_q[SUM_W-1:DIST_W] != '0) ? DIST_MAX : sh_q[DIST_W-1:0];
  assign r_try    = {rem_q, div_q[DIST_W+FRAC_W-1]};
  assign r_ge     = r_try >= {1'b0, min_q};
  assign s_try    = {srem_q[CONTRAST_W:0], quot_q[QUOT_W-1:QUOT_W-2]};
  assign s_trial  = {1'b0, root_q, 2'b01};
  assign s_ge     = s_try >= s_trial;
  assign out_free = !out_valid_o || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
      iter_q      <= '0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != ST_DONE) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            sh_q    <= job_i.sum;
            cnt_q   <= job_i.count;
            min_q   <= job_i.min;
            rem_q   <= '0;
            iter_q  <= MEAN_LAST;
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          rem_q[CNT_W-1:0] <= m_ge ? CNT_W'(m_try - {1'b0, cnt_q}) : m_try[CNT_W-1:0];
          sh_q   <= {sh_q[SUM_W-2:0], m_ge};
          iter_q <= iter_q - ITER_W'(1);
          if (iter_q == '0) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          mean_q <= mean_sat;
          zero_q <= min_q == '0;
          if (min_q == '0 || {{FRAC_W{1'b0}}, mean_sat[DIST_W-1:FRAC_W]} >= min_q) begin
            root_q  <= CONTRAST_SAT;
            state_q <= ST_DONE;
          end else begin
            div_q   <= {mean_sat, {FRAC_W{1'b0}}};
            rem_q   <= '0;
            quot_q  <= '0;
            iter_q  <= RATIO_LAST;
            state_q <= ST_RATIO;
          end
        end
        ST_RATIO: begin
          rem_q  <= r_ge ? DIST_W'(r_try - {1'b0, min_q}) : r_try[DIST_W-1:0];
          div_q  <= {div_q[DIST_W+FRAC_W-2:0], 1'b0};
          quot_q <= {quot_q[QUOT_W-2:0], r_ge};
          iter_q <= (iter_q == '0) ? ROOT_LAST : iter_q - ITER_W'(1);
          if (iter_q == '0) begin
            srem_q  <= '0;
            root_q  <= '0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          srem_q <= s_ge ? (CONTRAST_W+2)'(s_try - s_trial) : s_try[CONTRAST_W+1:0];
          quot_q <= {quot_q[QUOT_W-3:0], 2'b00};
          root_q <= {root_q[CONTRAST_W-2:0], s_ge};
          iter_q <= iter_q - ITER_W'(1);
          if (iter_q == '0) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            contrast_o  <= root_q;
            mean_dist_o <= mean_q;
            min_dist_o  <= min_q;
            zero_min_o  <= zero_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `RCQ_ASSERT(a_zero_saturates, clk_i, rst_ni, (out_valid_o && zero_min_o) |-> contrast_o == CONTRAST_SAT)
  `RCQ_ASSERT(a_root_iter, clk_i, rst_ni, (state_q == ST_ROOT) |-> iter_q <= ROOT_LAST)
  `RCQ_ASSERT(a_done_loads, clk_i, rst_ni, (state_q == ST_DONE && out_free) |=> out_valid_o && state_q == ST_IDLE)
  `RCQ_ASSERT(a_mean_bound, clk_i, rst_ni, (state_q == ST_MEAN) |-> rem_q[CNT_W-1:0] < cnt_q)
endmodule
